@@ rtl/core/pfdc_pkg.sv @@
// ============================================================================
// pfdc_pkg
// Shared types and constants of the presum fold with offset removal.
// ============================================================================
package pfdc_pkg;

    // BINS is a power of two: bin number and mean use shifts and masks
    localparam int BINS           = 64;
    localparam int BIN_W          = $clog2(BINS);
    localparam int BUFFER_SAMPLES = 2048;
    localparam int POS_W          = $clog2(BUFFER_SAMPLES);
    localparam int USED_SAMPLES   = (BUFFER_SAMPLES / BINS) * BINS;
    localparam int PHASE_W        = 8;
    localparam int SAMPLE_W       = 8;
    localparam int ACC_W          = 16;
    localparam int GAIN_W         = 8;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 8;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE = 2'd0,
        REG_FRAMES = 2'd1,
        REG_GAIN   = 2'd2
    } t_cfg_reg;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_LOAD = 2'd1,
        OP_ADD  = 2'd2
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [BIN_W-1:0]    bin;
        logic [SAMPLE_W-1:0] si;
        logic [SAMPLE_W-1:0] sq;
        logic                frame_end;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef enum logic [2:0] {
        BS_RUN,
        BS_DRAIN,
        BS_SUM,
        BS_SETTLE,
        BS_MEAN,
        BS_DRD,
        BS_DSUB,
        BS_DMUL
    } t_bstate;

endpackage

@@ rtl/core/presum_fold_dc_removal.sv @@
// ============================================================================
// presum_fold_dc_removal
// Folds complex samples into bins over a frame of buffers, then emits each
// bin with its mean offset removed and a gain applied.
// ============================================================================
// A sample is taken every cycle while the four-entry command queue has room;
// the bin memory does one read-modify-write per sample through its
// registered read port, overlapped. At the last sample of a frame the bin
// engine stops taking commands while it drains, sums the bins through the
// memory read port and forms the mean, then for each bin does a memory read,
// an offset subtract and a gain multiply, waiting while the output is
// stalled. During that time the queue fills and input ready drops.
// Configuration is one write per cycle, always ready.
module presum_fold_dc_removal
    import pfdc_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [SAMPLE_W-1:0]  i_sample_i,
    input  logic signed [SAMPLE_W-1:0]  i_sample_q,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [BIN_W-1:0]            o_bin_index,
    output logic signed [ACC_W-1:0]     o_bin_i,
    output logic signed [ACC_W-1:0]     o_bin_q,
    output logic                        o_last_bin
);

    logic               r_enable;
    logic [PHASE_W-1:0] r_frames_m1;
    logic [GAIN_W-1:0]  r_gain;
    logic               cfg_wr;
    logic               restart;
    logic               push;
    logic               pop;
    t_cmd               push_cmd;
    t_cmd               head_cmd;
    t_q_status          q_status;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign restart     = cfg_wr && (i_cfg_index == REG_ENABLE || i_cfg_index == REG_FRAMES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_frames_m1 <= '0;
            r_gain      <= GAIN_W'(1);
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                REG_ENABLE: r_enable    <= i_cfg_data[0];
                REG_FRAMES: r_frames_m1 <= i_cfg_data[PHASE_W-1:0];
                REG_GAIN:   r_gain      <= i_cfg_data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pfdc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample_i  (i_sample_i),
        .i_sample_q  (i_sample_q),
        .i_enable    (r_enable),
        .i_frames_m1 (r_frames_m1),
        .i_restart   (restart),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .i_q_status  (q_status)
    );

    pfdc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    pfdc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (head_cmd),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .i_gain      (r_gain),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_bin_index (o_bin_index),
        .o_bin_i     (o_bin_i),
        .o_bin_q     (o_bin_q),
        .o_last_bin  (o_last_bin)
    );

endmodule

@@ rtl/core/pfdc_front.sv @@
// ============================================================================
// pfdc_front
// Sample intake: tracks buffer position and buffer count, classifies each
// sample as load, add or ignore, and flags the end of a frame.
// ============================================================================
module pfdc_front
    import pfdc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_sample_i,
    input  logic signed [SAMPLE_W-1:0] i_sample_q,
    input  logic                       i_enable,
    input  logic [PHASE_W-1:0]         i_frames_m1,
    input  logic                       i_restart,
    output logic                       o_push,
    output t_cmd                       o_cmd,
    input  t_q_status                  i_q_status
);

    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   n_pos;
    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] n_phase;
    logic               in_used;
    logic               last_of_buf;
    logic               frame_end;
    logic               accept;
    t_op                op;

    assign o_in_ready = !i_enable || !i_q_status.full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        in_used     = {1'b0, r_pos} < (POS_W+1)'(USED_SAMPLES);
        last_of_buf = r_pos == POS_W'(BUFFER_SAMPLES - 1);
        frame_end   = last_of_buf && (r_phase == i_frames_m1);
        if (!in_used) begin
            op = OP_NONE;
        end else if (r_phase == '0 && r_pos < POS_W'(BINS)) begin
            op = OP_LOAD;
        end else begin
            op = OP_ADD;
        end
        o_push        = accept && i_enable && (op != OP_NONE || frame_end);
        o_cmd.op        = op;
        o_cmd.bin       = r_pos[BIN_W-1:0];
        o_cmd.si        = i_sample_i;
        o_cmd.sq        = i_sample_q;
        o_cmd.frame_end = frame_end;
        n_pos   = r_pos;
        n_phase = r_phase;
        if (accept && i_enable) begin
            if (last_of_buf) begin
                n_pos   = '0;
                n_phase = frame_end ? '0 : r_phase + 1'b1;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_pos   <= '0;
            r_phase <= '0;
        end else begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
        end
    end

endmodule

@@ rtl/core/pfdc_queue.sv @@
// ============================================================================
// pfdc_queue
// Short command queue between sample intake and bin engine.
// ============================================================================
module pfdc_queue
    import pfdc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              do_push;
    logic              do_pop;

    assign o_status.full  = r_count == (QPTR_W+1)'(QUEUE_DEPTH);
    assign o_status.empty = r_count == '0;
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_cmd          = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
        end
    end

endmodule

@@ rtl/core/pfdc_back.sv @@
// ============================================================================
// pfdc_back
// Bin engine: folds samples into the bin memory, and at frame end sums the
// bins, forms the mean and emits every bin with offset removed and gain.
// ============================================================================
module pfdc_back
    import pfdc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    input  t_q_status                i_q_status,
    output logic                     o_pop,
    input  logic [GAIN_W-1:0]        i_gain,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [BIN_W-1:0]         o_bin_index,
    output logic signed [ACC_W-1:0]  o_bin_i,
    output logic signed [ACC_W-1:0]  o_bin_q,
    output logic                     o_last_bin
);

    t_bstate                    r_state;
    t_bstate                    n_state;
    logic [2*ACC_W-1:0]         r_mem [BINS];
    logic [2*ACC_W-1:0]         r_rd_data;
    logic [BIN_W-1:0]           rd_addr;
    logic [BIN_W-1:0]           r_cnt;
    logic                       cnt_last;
    logic                       load_out;
    logic                       r_wr_pend;
    t_op                        r_wr_op;
    logic [BIN_W-1:0]           r_wr_bin;
    logic [ACC_W-1:0]           r_wr_si;
    logic [ACC_W-1:0]           r_wr_sq;
    logic [2*ACC_W-1:0]         wr_data;
    logic                       r_sum_en;
    logic [ACC_W-1:0]           r_sum_i;
    logic [ACC_W-1:0]           r_sum_q;
    logic signed [ACC_W:0]      bias_i;
    logic signed [ACC_W:0]      bias_q;
    logic [ACC_W-1:0]           r_mean_i;
    logic [ACC_W-1:0]           r_mean_q;
    logic [ACC_W-1:0]           r_diff_i;
    logic [ACC_W-1:0]           r_diff_q;
    logic [ACC_W+GAIN_W-1:0]    prod_i;
    logic [ACC_W+GAIN_W-1:0]    prod_q;

    assign cnt_last = r_cnt == BIN_W'(BINS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        rd_addr  = r_cnt;
        load_out = 1'b0;
        unique case (r_state)
            BS_RUN: begin
                rd_addr = i_cmd.bin;
                if (!i_q_status.empty) begin
                    o_pop = 1'b1;
                    if (i_cmd.frame_end) begin
                        n_state = BS_DRAIN;
                    end
                end
            end
            BS_DRAIN: begin
                n_state = BS_SUM;
            end
            BS_SUM: begin
                if (cnt_last) begin
                    n_state = BS_SETTLE;
                end
            end
            BS_SETTLE: begin
                n_state = BS_MEAN;
            end
            BS_MEAN: begin
                n_state = BS_DRD;
            end
            BS_DRD: begin
                n_state = BS_DSUB;
            end
            BS_DSUB: begin
                n_state = BS_DMUL;
            end
            BS_DMUL: begin
                if (!o_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = cnt_last ? BS_RUN : BS_DRD;
                end
            end
            default: begin
                n_state = BS_RUN;
            end
        endcase
    end

    // bin memory: one read and one write port, registered read
    always_comb begin
        wr_data = {r_rd_data[2*ACC_W-1:ACC_W] + r_wr_sq, r_rd_data[ACC_W-1:0] + r_wr_si};
        if (r_wr_op == OP_LOAD) begin
            wr_data = {r_wr_sq, r_wr_si};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[rd_addr];
        if (r_wr_pend) begin
            r_mem[r_wr_bin] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pend <= 1'b0;
            r_sum_en  <= 1'b0;
        end else begin
            r_wr_pend <= o_pop && (i_cmd.op != OP_NONE);
            r_sum_en  <= r_state == BS_SUM;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_op  <= i_cmd.op;
        r_wr_bin <= i_cmd.bin;
        r_wr_si  <= {{(ACC_W-SAMPLE_W){i_cmd.si[SAMPLE_W-1]}}, i_cmd.si};
        r_wr_sq  <= {{(ACC_W-SAMPLE_W){i_cmd.sq[SAMPLE_W-1]}}, i_cmd.sq};
    end

    // mean truncates toward zero: bias negative sums before the shift
    assign bias_i = $signed({r_sum_i[ACC_W-1], r_sum_i})
                  + (r_sum_i[ACC_W-1] ? (ACC_W+1)'(BINS - 1) : '0);
    assign bias_q = $signed({r_sum_q[ACC_W-1], r_sum_q})
                  + (r_sum_q[ACC_W-1] ? (ACC_W+1)'(BINS - 1) : '0);

    assign prod_i = {{GAIN_W{1'b0}}, r_diff_i} * {{ACC_W{1'b0}}, i_gain};
    assign prod_q = {{GAIN_W{1'b0}}, r_diff_q} * {{ACC_W{1'b0}}, i_gain};

    always_ff @(posedge i_clk) begin
        if (r_state == BS_DRAIN) begin
            r_sum_i <= '0;
            r_sum_q <= '0;
        end else if (r_sum_en) begin
            r_sum_i <= r_sum_i + r_rd_data[ACC_W-1:0];
            r_sum_q <= r_sum_q + r_rd_data[2*ACC_W-1:ACC_W];
        end
        if (r_state == BS_MEAN) begin
            r_mean_i <= ACC_W'(bias_i >>> BIN_W);
            r_mean_q <= ACC_W'(bias_q >>> BIN_W);
        end
        if (r_state == BS_DSUB) begin
            r_diff_i <= r_rd_data[ACC_W-1:0] - r_mean_i;
            r_diff_q <= r_rd_data[2*ACC_W-1:ACC_W] - r_mean_q;
        end
        if (load_out) begin
            o_bin_index <= r_cnt;
            o_bin_i     <= $signed(prod_i[ACC_W-1:0]);
            o_bin_q     <= $signed(prod_q[ACC_W-1:0]);
            o_last_bin  <= cnt_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (r_state == BS_SUM || load_out) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (load_out) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for presum_fold_dc_removal: random complex samples are
// folded into bins by a predictor, whose offset-removed and scaled dumps are
// compared bin by bin with the results of the block under random back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    import pfdc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 4 * BINS + 16;
    localparam int LONG_HOLD     = 600;
    localparam int LIMIT_CYCLES  = 600000;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [SAMPLE_W-1:0]  CORNERS [9] = '{
        8'h7F, 8'h80, 8'h00, 8'hFF, 8'h01, 8'h55, 8'hAA, 8'h40, 8'hC0
    };

    typedef struct {
        logic [SAMPLE_W-1:0] si;
        logic [SAMPLE_W-1:0] sq;
    } t_iq;

    typedef struct {
        logic [BIN_W-1:0] idx;
        logic [ACC_W-1:0] vi;
        logic [ACC_W-1:0] vq;
        logic             last;
    } t_bin_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic signed [SAMPLE_W-1:0] i_sample_i = '0;
    logic signed [SAMPLE_W-1:0] i_sample_q = '0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [BIN_W-1:0]           o_bin_index;
    logic signed [ACC_W-1:0]    o_bin_i;
    logic signed [ACC_W-1:0]    o_bin_q;
    logic                       o_last_bin;

    presum_fold_dc_removal u_top (.*);

    // predictor state and configuration
    logic [ACC_W-1:0] acc_i [BINS];
    logic [ACC_W-1:0] acc_q [BINS];
    int               buf_pos = 0;
    logic [7:0]       buf_phase = '0;
    logic             run_en = 1'b0;
    logic [7:0]       frames_m1 = '0;
    logic [7:0]       gain_q = 8'd1;

    t_iq         pending [$];
    t_bin_result bins_due [$];

    int in_max_gap = 5;
    int out_max_gap = 5;
    int in_wait = 0;
    int out_wait = 0;
    int hold_left = 0;
    bit hold_wanted = 1'b0;
    bit hold_used = 1'b0;
    int cycle_count = 0;
    int samples_taken = 0;
    int bins_checked = 0;
    int frames_done = 0;
    int mismatches = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("** presum_fold_dc_removal: FAILED **");
            $finish;
        end
    end

    task automatic fold_sample(input logic [SAMPLE_W-1:0] si, input logic [SAMPLE_W-1:0] sq);
        logic [ACC_W-1:0] wi, wq, sum_i, sum_q, di, dq;
        int b, mean_i, mean_q;
        t_bin_result r;
        if (!run_en)
            return;
        wi = {{(ACC_W-SAMPLE_W){si[SAMPLE_W-1]}}, si};
        wq = {{(ACC_W-SAMPLE_W){sq[SAMPLE_W-1]}}, sq};
        if (buf_pos < USED_SAMPLES) begin
            b = buf_pos % BINS;
            if (buf_phase == 0 && buf_pos < BINS) begin
                acc_i[b] = wi;
                acc_q[b] = wq;
            end else begin
                acc_i[b] = acc_i[b] + wi;
                acc_q[b] = acc_q[b] + wq;
            end
        end
        buf_pos++;
        if (buf_pos < BUFFER_SAMPLES)
            return;
        buf_pos = 0;
        if (buf_phase != frames_m1) begin
            buf_phase = buf_phase + 8'd1;
            return;
        end
        buf_phase = '0;
        sum_i = '0;
        sum_q = '0;
        for (int k = 0; k < BINS; k++) begin
            sum_i = sum_i + acc_i[k];
            sum_q = sum_q + acc_q[k];
        end
        mean_i = $signed(sum_i) / BINS;
        mean_q = $signed(sum_q) / BINS;
        for (int k = 0; k < BINS; k++) begin
            di = acc_i[k] - ACC_W'(mean_i);
            dq = acc_q[k] - ACC_W'(mean_q);
            r.idx  = BIN_W'(k);
            r.vi   = ACC_W'(di * gain_q);
            r.vq   = ACC_W'(dq * gain_q);
            r.last = (k == BINS - 1);
            bins_due.push_back(r);
        end
        frames_done++;
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_ENABLE: begin
                run_en    = data[0];
                buf_pos   = 0;
                buf_phase = '0;
            end
            REG_FRAMES: begin
                frames_m1 = data;
                buf_pos   = 0;
                buf_phase = '0;
            end
            REG_GAIN: begin
                gain_q = data;
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
        end
    endtask

    task automatic check_bin();
        t_bin_result r;
        if (bins_due.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected bin %0d, expected none, got i=%h q=%h last=%b",
                     $time, o_bin_index, o_bin_i, o_bin_q, o_last_bin);
            return;
        end
        r = bins_due.pop_front();
        check_field("bin_index", r.idx, o_bin_index);
        check_field("bin_i", r.vi, $unsigned(o_bin_i));
        check_field("bin_q", r.vq, $unsigned(o_bin_q));
        check_field("last_bin", r.last, o_last_bin);
        bins_checked++;
    endtask

    // sample driver
    always @(posedge i_clk) begin : tx_proc
        t_iq s;
        int  gap;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_wait    <= 0;
        end else if (i_in_valid && o_in_ready) begin
            fold_sample(i_sample_i, i_sample_q);
            samples_taken++;
            gap = $urandom_range(0, in_max_gap);
            if (gap == 0 && pending.size() != 0) begin
                s = pending.pop_front();
                i_sample_i <= s.si;
                i_sample_q <= s.sq;
            end else begin
                i_in_valid <= 1'b0;
                in_wait    <= (gap == 0) ? 0 : gap - 1;
            end
        end else if (!i_in_valid) begin
            if (in_wait != 0) begin
                in_wait <= in_wait - 1;
            end else if (pending.size() != 0) begin
                s = pending.pop_front();
                i_sample_i <= s.si;
                i_sample_q <= s.sq;
                i_in_valid <= 1'b1;
            end
        end
    end

    // long output hold-off, fired once on the first dump after it is armed
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_wanted && !hold_used && o_out_valid) begin
            hold_left <= LONG_HOLD;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin : rx_proc
        int gap;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_wait    <= 0;
        end else begin
            if (o_out_valid && i_out_ready)
                check_bin();
            if (hold_left != 0) begin
                i_out_ready <= 1'b0;
            end else if (o_out_valid && i_out_ready) begin
                gap = $urandom_range(0, out_max_gap);
                out_wait    <= gap;
                i_out_ready <= (gap == 0);
            end else if (out_wait != 0) begin
                out_wait    <= out_wait - 1;
                i_out_ready <= (out_wait == 1);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_extreme();
        case ($urandom_range(0, 7))
            0, 1, 2: return 8'h7F;
            3, 4, 5: return 8'h80;
            6:       return 8'hFF;
            default: return 8'h01;
        endcase
    endfunction

    task automatic add_samples(input int count, input bit extreme);
        t_iq s;
        repeat (count) begin
            s.si = extreme ? pick_extreme() : SAMPLE_W'($urandom);
            s.sq = extreme ? pick_extreme() : SAMPLE_W'($urandom);
            pending.push_back(s);
        end
    endtask

    task automatic add_corners();
        t_iq s;
        for (int a = 0; a < 9; a++) begin
            s.si = CORNERS[a];
            s.sq = CORNERS[a];
            pending.push_back(s);
            s.sq = CORNERS[8-a];
            pending.push_back(s);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        apply_reg(idx, data);
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (pending.size() != 0 || i_in_valid || bins_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        for (int k = 0; k < BINS; k++) begin
            acc_i[k] = '0;
            acc_q[k] = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drop samples while disabled
        add_samples(8, 1'b0);
        wait_drained();

        // two back-to-back frames at reset gain, dump held off to fill the block
        write_reg(REG_ENABLE, 8'h01);
        hold_wanted = 1'b1;
        add_corners();
        add_samples(2 * BUFFER_SAMPLES - 18, 1'b0);
        wait_drained();

        in_max_gap  = 0;
        out_max_gap = 0;
        write_reg(REG_GAIN, 8'h00);
        write_reg(REG_FRAMES, 8'd1);
        add_samples(2 * BUFFER_SAMPLES, 1'b0);
        wait_drained();

        in_max_gap  = 2;
        out_max_gap = 5;
        write_reg(REG_GAIN, 8'hFF);
        write_reg(REG_FRAMES, 8'd0);
        add_samples(BUFFER_SAMPLES, 1'b1);
        wait_drained();

        // cut a long frame short by reprogramming its length
        in_max_gap = 5;
        write_reg(REG_SPARE, 8'h5A);
        write_reg(REG_FRAMES, 8'hFF);
        add_samples(300, 1'b0);
        wait_drained();
        write_reg(REG_FRAMES, 8'd2);
        write_reg(REG_GAIN, CFG_DATA_W'($urandom_range(2, 254)));
        add_samples(3 * BUFFER_SAMPLES, 1'b0);
        wait_drained();

        write_reg(REG_ENABLE, 8'hFE);
        add_samples(50, 1'b0);
        wait_drained();
        write_reg(REG_ENABLE, 8'h01);
        write_reg(REG_FRAMES, 8'd0);
        write_reg(REG_GAIN, 8'd1);
        add_samples(BUFFER_SAMPLES, 1'b0);
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("Accepted %0d samples, predicted %0d dumps, checked %0d bins, %0d mismatches.",
                 samples_taken, frames_done, bins_checked, mismatches);
        $display("Gains 0, 1, 255 and random; 1, 2, 3 buffers per dump; cut frame; disabled input.");
        if (mismatches == 0 && bins_due.size() == 0) begin
            $display("** presum_fold_dc_removal: PASSED **");
        end else begin
            $display("%0t: %0d bins still expected", $time, bins_due.size());
            $display("** presum_fold_dc_removal: FAILED **");
        end
        $finish;
    end

endmodule

@@ presum_fold_dc_removal.f @@
rtl/core/pfdc_pkg.sv
rtl/core/pfdc_front.sv
rtl/core/pfdc_queue.sv
rtl/core/pfdc_back.sv
rtl/core/presum_fold_dc_removal.sv
dv/tb_top.sv
